FILE: sv/c_like_token_scanner_defines.svh
// ----------------------------------------------------------------------------
// c_like_token_scanner_defines.svh
// Assertion macros for the token scanner; they expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef C_LIKE_TOKEN_SCANNER_DEFINES_SVH
`define C_LIKE_TOKEN_SCANNER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define CTOK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctok: assertion failed");
// Next-cycle implication.
`define CTOK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctok: assertion failed");
`else
`define CTOK_ASSERT_NOW(lbl, ante, cons)
`define CTOK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/ctok_pkg.sv
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types and constants of the token scanner.
// ----------------------------------------------------------------------------
package ctok_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // result queue between the scanner core and the m_ channel
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] value;
        logic        last;
    } tok_t;

    // results of one source byte: 0, 1 or 2 tokens
    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } tok_pair_t;

    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
        logic                  room2;
        logic                  empty;
    } fifo_stat_t;

endpackage

FILE: sv/ctok_step.sv
// ----------------------------------------------------------------------------
// ctok_step
// Scanner state and the per-byte next-state / token decode.
// ----------------------------------------------------------------------------
module ctok_step #(
    parameter int VALUE_WIDTH = ctok_pkg::VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  logic [7:0]         src_byte,
    output ctok_pkg::tok_pair_t pair
);
    import ctok_pkg::*;

    localparam int CW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    // token kinds
    localparam logic [5:0] K_END       = 6'd0;
    localparam logic [5:0] K_ID_PIECE  = 6'd1;
    localparam logic [5:0] K_ID_END    = 6'd2;
    localparam logic [5:0] K_NUM       = 6'd3;
    localparam logic [5:0] K_CHAR      = 6'd4;
    localparam logic [5:0] K_STR_PIECE = 6'd5;
    localparam logic [5:0] K_STR_END   = 6'd6;
    localparam logic [5:0] K_INC       = 6'd7;
    localparam logic [5:0] K_ADD       = 6'd8;
    localparam logic [5:0] K_DEC       = 6'd9;
    localparam logic [5:0] K_SUB       = 6'd10;
    localparam logic [5:0] K_MUL       = 6'd11;
    localparam logic [5:0] K_DIV       = 6'd12;
    localparam logic [5:0] K_LAND      = 6'd13;
    localparam logic [5:0] K_AND       = 6'd14;
    localparam logic [5:0] K_LOR       = 6'd15;
    localparam logic [5:0] K_OR        = 6'd16;
    localparam logic [5:0] K_NE        = 6'd17;
    localparam logic [5:0] K_NOT       = 6'd18;
    localparam logic [5:0] K_GE        = 6'd19;
    localparam logic [5:0] K_GT        = 6'd20;
    localparam logic [5:0] K_LE        = 6'd21;
    localparam logic [5:0] K_LT        = 6'd22;
    localparam logic [5:0] K_EQ        = 6'd23;
    localparam logic [5:0] K_ASSIGN    = 6'd24;
    localparam logic [5:0] K_XOR       = 6'd25;
    localparam logic [5:0] K_TILDE     = 6'd26;
    localparam logic [5:0] K_COMMA     = 6'd27;
    localparam logic [5:0] K_COLON     = 6'd28;
    localparam logic [5:0] K_SEMI      = 6'd29;
    localparam logic [5:0] K_LPAREN    = 6'd30;
    localparam logic [5:0] K_RPAREN    = 6'd31;
    localparam logic [5:0] K_LBRACK    = 6'd32;
    localparam logic [5:0] K_RBRACK    = 6'd33;
    localparam logic [5:0] K_LBRACE    = 6'd34;
    localparam logic [5:0] K_RBRACE    = 6'd35;
    localparam logic [5:0] K_ERR_CHAR  = 6'd36;
    localparam logic [5:0] K_ERR_STR   = 6'd37;
    localparam logic [5:0] K_ERR_CMT   = 6'd38;

    // characters
    localparam logic [7:0] C_EOI    = 8'hFF;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_BAR    = 8'h7C;
    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_EQ     = 8'h3D;
    localparam logic [7:0] C_CARET  = 8'h5E;
    localparam logic [7:0] C_TILDE  = 8'h7E;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_LC_A   = 8'h61;
    localparam logic [7:0] C_LC_Z   = 8'h7A;
    localparam logic [7:0] C_UC_A   = 8'h41;
    localparam logic [7:0] C_UC_Z   = 8'h5A;
    localparam logic [7:0] C_LC_N   = 8'h6E;
    localparam logic [7:0] C_LC_T   = 8'h74;

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE, M_STR, M_STR_ESC,
        M_HASH, M_SLASH, M_LINE, M_BLOCK, M_BLOCK_STAR,
        M_PLUS, M_MINUS, M_AMP, M_BAR, M_BANG, M_GT, M_LT, M_EQ, M_HALT
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic       emit;
        logic [5:0] kind;
        logic [7:0] val;
    } start_t;

    typedef struct packed {
        logic [7:0] second;
        logic [5:0] pair_kind;
        logic [5:0] alone_kind;
    } op_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } esc_t;

    function automatic logic is_ident(input logic [7:0] b);
        return (b == C_UNDER) || (b >= C_LC_A && b <= C_LC_Z) ||
               (b >= C_UC_A && b <= C_UC_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= C_ZERO) && (b <= C_NINE);
    endfunction

    // byte scanned as the first byte of a token
    function automatic start_t start_tok(input logic [7:0] b);
        start_t s;
        s.mode = M_IDLE;
        s.emit = 1'b0;
        s.kind = K_END;
        s.val  = 8'd0;
        if (is_ident(b)) begin
            s.mode = M_IDENT;
            s.emit = 1'b1;
            s.kind = K_ID_PIECE;
            s.val  = b;
        end else if (is_digit(b)) begin
            s.mode = M_NUM;
        end else begin
            case (b)
                C_EOI:    begin s.emit = 1'b1; s.kind = K_END;    end
                C_SQUOTE: s.mode = M_CH_OPEN;
                C_DQUOTE: s.mode = M_STR;
                C_HASH:   s.mode = M_HASH;
                C_SLASH:  s.mode = M_SLASH;
                C_PLUS:   s.mode = M_PLUS;
                C_MINUS:  s.mode = M_MINUS;
                C_AMP:    s.mode = M_AMP;
                C_BAR:    s.mode = M_BAR;
                C_BANG:   s.mode = M_BANG;
                C_GT:     s.mode = M_GT;
                C_LT:     s.mode = M_LT;
                C_EQ:     s.mode = M_EQ;
                C_STAR:   begin s.emit = 1'b1; s.kind = K_MUL;    end
                C_CARET:  begin s.emit = 1'b1; s.kind = K_XOR;    end
                C_TILDE:  begin s.emit = 1'b1; s.kind = K_TILDE;  end
                C_COMMA:  begin s.emit = 1'b1; s.kind = K_COMMA;  end
                C_COLON:  begin s.emit = 1'b1; s.kind = K_COLON;  end
                C_SEMI:   begin s.emit = 1'b1; s.kind = K_SEMI;   end
                C_LPAREN: begin s.emit = 1'b1; s.kind = K_LPAREN; end
                C_RPAREN: begin s.emit = 1'b1; s.kind = K_RPAREN; end
                C_LBRACK: begin s.emit = 1'b1; s.kind = K_LBRACK; end
                C_RBRACK: begin s.emit = 1'b1; s.kind = K_RBRACK; end
                C_LBRACE: begin s.emit = 1'b1; s.kind = K_LBRACE; end
                C_RBRACE: begin s.emit = 1'b1; s.kind = K_RBRACE; end
                default:  s.emit = 1'b0;  // blanks, NUL, unknown bytes
            endcase
        end
        return s;
    endfunction

    function automatic op_t op_info(input mode_t m);
        op_t o;
        case (m)
            M_PLUS:  o = '{second: C_PLUS,  pair_kind: K_INC,  alone_kind: K_ADD};
            M_MINUS: o = '{second: C_MINUS, pair_kind: K_DEC,  alone_kind: K_SUB};
            M_AMP:   o = '{second: C_AMP,   pair_kind: K_LAND, alone_kind: K_AND};
            M_BAR:   o = '{second: C_BAR,   pair_kind: K_LOR,  alone_kind: K_OR};
            M_BANG:  o = '{second: C_EQ,    pair_kind: K_NE,   alone_kind: K_NOT};
            M_GT:    o = '{second: C_EQ,    pair_kind: K_GE,   alone_kind: K_GT};
            M_LT:    o = '{second: C_EQ,    pair_kind: K_LE,   alone_kind: K_LT};
            default: o = '{second: C_EQ,    pair_kind: K_EQ,   alone_kind: K_ASSIGN};
        endcase
        return o;
    endfunction

    function automatic esc_t escape(input logic [7:0] b, input logic [7:0] quote);
        esc_t e;
        e.ok = 1'b1;
        e.val = b;
        if (b == C_LC_N)       e.val = C_NL;
        else if (b == C_LC_T)  e.val = C_TAB;
        else if (b == C_ZERO)  e.val = C_NUL;
        else if (b == C_BSLASH || b == quote) e.val = b;
        else                   e.ok = 1'b0;
        return e;
    endfunction

    mode_t                  mode_reg, mode_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [7:0]             pend_reg, pend_next;

    start_t                 st;
    op_t                    op;
    esc_t                   esc_ch, esc_str;
    logic                   restart, fail_en;
    logic [5:0]             fail_kind;
    logic [1:0]             cnt;
    logic [5:0]             k0, k1;
    logic [31:0]            v0, v1;
    logic [VALUE_WIDTH-1:0] acc_x10;
    logic                   b_eol;

    assign st      = start_tok(src_byte);
    assign op      = op_info(mode_reg);
    assign esc_ch  = escape(src_byte, C_SQUOTE);
    assign esc_str = escape(src_byte, C_DQUOTE);
    assign b_eol   = (src_byte == C_EOI) || (src_byte == C_NL);
    // x10 as shift-and-add, wraps at VALUE_WIDTH
    assign acc_x10 = (acc_reg << 3) + (acc_reg << 1)
                   + VALUE_WIDTH'(src_byte[3:0]);

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        restart   = 1'b0;
        fail_en   = 1'b0;
        fail_kind = K_ERR_CHAR;
        cnt       = 2'd0;
        k0        = K_END;
        v0        = 32'd0;
        k1        = K_END;
        v1        = 32'd0;

        case (mode_reg)
            M_IDENT: begin
                if (is_ident(src_byte)) begin
                    cnt = 2'd1; k0 = K_ID_PIECE; v0 = 32'(src_byte);
                end else begin
                    cnt = 2'd1; k0 = K_ID_END; restart = 1'b1;
                end
            end
            M_NUM: begin
                if (is_digit(src_byte)) begin
                    acc_next = acc_x10;
                end else begin
                    cnt = 2'd1; k0 = K_NUM; v0 = 32'(acc_reg[CW-1:0]);
                    restart = 1'b1;
                end
            end
            M_CH_OPEN: begin
                if (b_eol || src_byte == C_SQUOTE) begin
                    fail_en = 1'b1; fail_kind = K_ERR_CHAR;
                end else if (src_byte == C_BSLASH) begin
                    mode_next = M_CH_ESC;
                end else begin
                    pend_next = src_byte; mode_next = M_CH_CLOSE;
                end
            end
            M_CH_ESC: begin
                if (b_eol) begin
                    fail_en = 1'b1; fail_kind = K_ERR_CHAR;
                end else begin
                    pend_next = esc_ch.val;  // unknown escape keeps the byte
                    mode_next = M_CH_CLOSE;
                end
            end
            M_CH_CLOSE: begin
                if (src_byte == C_SQUOTE) begin
                    cnt = 2'd1; k0 = K_CHAR; v0 = 32'(pend_reg); mode_next = M_IDLE;
                end else begin
                    fail_en = 1'b1; fail_kind = K_ERR_CHAR;
                end
            end
            M_STR: begin
                if (src_byte == C_DQUOTE) begin
                    cnt = 2'd1; k0 = K_STR_END; mode_next = M_IDLE;
                end else if (b_eol) begin
                    fail_en = 1'b1; fail_kind = K_ERR_STR;
                end else if (src_byte == C_BSLASH) begin
                    mode_next = M_STR_ESC;
                end else begin
                    cnt = 2'd1; k0 = K_STR_PIECE; v0 = 32'(src_byte);
                end
            end
            M_STR_ESC: begin
                if (b_eol) begin
                    fail_en = 1'b1; fail_kind = K_ERR_STR;
                end else begin
                    if (esc_str.ok) begin
                        cnt = 2'd1; k0 = K_STR_PIECE; v0 = 32'(esc_str.val);
                    end
                    mode_next = M_STR;
                end
            end
            M_HASH, M_LINE: begin
                if (b_eol) restart = 1'b1;
            end
            M_SLASH: begin
                if (src_byte == C_SLASH) begin
                    mode_next = M_LINE;
                end else if (src_byte == C_STAR) begin
                    mode_next = M_BLOCK;
                end else begin
                    cnt = 2'd1; k0 = K_DIV; restart = 1'b1;
                end
            end
            M_BLOCK, M_BLOCK_STAR: begin
                if (src_byte == C_EOI) begin
                    fail_en = 1'b1; fail_kind = K_ERR_CMT;
                end else if (mode_reg == M_BLOCK_STAR && src_byte == C_SLASH) begin
                    mode_next = M_IDLE;
                end else begin
                    mode_next = (src_byte == C_STAR) ? M_BLOCK_STAR : M_BLOCK;
                end
            end
            M_PLUS, M_MINUS, M_AMP, M_BAR, M_BANG, M_GT, M_LT, M_EQ: begin
                if (src_byte == op.second) begin
                    cnt = 2'd1; k0 = op.pair_kind; mode_next = M_IDLE;
                end else begin
                    cnt = 2'd1; k0 = op.alone_kind; restart = 1'b1;
                end
            end
            M_HALT: begin
                if (src_byte == C_EOI) begin
                    cnt = 2'd1; k0 = K_END; mode_next = M_IDLE;
                end
            end
            default: restart = 1'b1;
        endcase

        // byte reopens a token; its own result goes after any pending one
        if (restart) begin
            mode_next = st.mode;
            acc_next  = is_digit(src_byte) ? VALUE_WIDTH'(src_byte[3:0]) : '0;
            if (st.emit) begin
                if (cnt == 2'd0) begin
                    cnt = 2'd1; k0 = st.kind; v0 = 32'(st.val);
                end else begin
                    cnt = 2'd2; k1 = st.kind; v1 = 32'(st.val);
                end
            end
        end

        // errors always come first; end of input also closes with END
        if (fail_en) begin
            k0 = fail_kind;
            v0 = 32'd0;
            if (src_byte == C_EOI) begin
                cnt = 2'd2; k1 = K_END; v1 = 32'd0; mode_next = M_IDLE;
            end else begin
                cnt = 2'd1; mode_next = M_HALT;
            end
        end
    end

    assign pair.count        = cnt;
    assign pair.first.kind   = k0;
    assign pair.first.value  = v0;
    assign pair.first.last   = (cnt == 2'd1);
    assign pair.second.kind  = k1;
    assign pair.second.value = v1;
    assign pair.second.last  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            acc_reg  <= '0;
            pend_reg <= '0;
        end else if (take) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

FILE: sv/ctok_fifo.sv
// ----------------------------------------------------------------------------
// ctok_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module ctok_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ctok_pkg::tok_pair_t  pair,
    input  logic                 pop,
    output ctok_pkg::tok_t       head,
    output ctok_pkg::fifo_stat_t stat
);
    import ctok_pkg::*;

    tok_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;
    logic [1:0]            n_push;

    assign n_push      = push ? pair.count : 2'd0;
    assign wr_ptr_p1   = wr_ptr_reg + FIFO_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign level_next  = level_reg + FIFO_LVL_W'(n_push) - FIFO_LVL_W'(pop);

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) mem[wr_ptr_reg] <= pair.first;
        if (n_push == 2'd2) mem[wr_ptr_p1]  <= pair.second;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.room2 = (level_reg <= FIFO_LVL_W'(FIFO_DEPTH - 2));
    assign stat.empty = (level_reg == '0);

endmodule

FILE: sv/c_like_token_scanner.sv
// ----------------------------------------------------------------------------
// c_like_token_scanner
// Byte-serial scanner for a small C-like language.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one source byte per transfer (s_source_byte); 8'hFF marks end
//   of input. m_ channel: tokens, one per transfer (kind, value, last flag).
//   A byte yields zero, one or two tokens; m_last_of_run marks the final
//   token of a byte, so the producing byte can be matched up downstream.
// Output: the tokens of a byte are written into the result queue at the edge
//   that accepts the byte; m_ presents the head of that queue.
// Throughput: one byte per cycle while s_ready is high. The scanner core
//   updates its state once per accepted byte; the bound is the m_ side, which
//   drains one token per cycle while m_ready is high, so bytes that yield two
//   tokens let the queue fill up. s_ready stays high while the 4-entry result
//   queue has room for two tokens.
// Reset: aresetn (synchronous, active low) returns the scanner to idle
//   between tokens and empties the result queue.
// Stall: while m_ready is low the queue holds its tokens; s_ready drops as
//   soon as fewer than two entries are free, and no token is lost.
// ----------------------------------------------------------------------------
`include "c_like_token_scanner_defines.svh"

module c_like_token_scanner #(
    parameter int VALUE_WIDTH = ctok_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [31:0] m_token_value,
    output logic        m_last_of_run
);
    import ctok_pkg::*;

    tok_pair_t  pair;
    tok_t       head;
    fifo_stat_t fifo_stat;
    logic       s_xfer;
    logic       m_xfer;

    // a byte transfer updates the core and pushes its tokens in the same edge
    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    ctok_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (s_xfer),
        .src_byte (s_source_byte),
        .pair     (pair)
    );

    // queue decouples the two sides so a stalled receiver does not
    // stop the input until the queue is nearly full
    ctok_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_xfer),
        .pair    (pair),
        .pop     (m_xfer),
        .head    (head),
        .stat    (fifo_stat)
    );

    assign s_ready       = fifo_stat.room2;
    assign m_valid       = !fifo_stat.empty;
    assign m_token_kind  = head.kind;
    assign m_token_value = head.value;
    assign m_last_of_run = head.last;

    // a byte that yields tokens makes the m_ side valid the next cycle
    `CTOK_ASSERT_NEXT(a_tokens_visible, s_xfer && (pair.count != 2'd0), m_valid)
    // the ready rule must keep the queue from overflowing
    `CTOK_ASSERT_NOW(a_no_overflow, 1'b1, fifo_stat.level <= FIFO_LVL_W'(FIFO_DEPTH))
    // with two tokens, only the second carries the last flag
    `CTOK_ASSERT_NOW(a_last_on_second, s_xfer && (pair.count == 2'd2), pair.second.last && !pair.first.last)

endmodule
